/* rtl/obm_pkg.sv */
package obm_pkg;

    localparam int TICKERS_DEF    = 1024;
    localparam int ORDERS_DEF     = 16;
    localparam int PRICE_BITS_DEF = 16;
    localparam int QTY_BITS_DEF   = 16;
    localparam int MAX_RESULTS    = 32;
    localparam int TICK_W         = 10;
    localparam int FIELD_W        = 16;

    typedef enum logic [1:0] {
        ACT_ADD_BUY  = 2'd0,
        ACT_ADD_SELL = 2'd1,
        ACT_MATCH    = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_STORED  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_TRADE   = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         action;
        logic [TICK_W-1:0]  ticker;
        logic [FIELD_W-1:0] price;
        logic [FIELD_W-1:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TICK_W-1:0]  ticker_out;
        logic [FIELD_W-1:0] buy_price;
        logic [FIELD_W-1:0] sell_price;
        logic [FIELD_W-1:0] traded_qty;
        logic               last;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;   // capture input item
        logic rd_fill;     // read fill counts
        logic wr_add;      // append order, bump fill
        logic rd_buy;      // read buy entry at buy index
        logic rd_sell;     // read sell entry at sell index
        logic trade;       // write back reduced quantities
        logic nxt_buy;     // advance buy index, clear sell index
        logic nxt_sell;    // advance sell index
        logic emit;        // load output register
        logic [1:0] kind;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_busy;    // fill counts are still being cleared
        logic is_add;
        logic is_match;
        logic add_ok;
        logic buy_end;
        logic sell_end;
        logic buy_zero;
        logic sell_skip;   // zero quantity or price too high
        logic buy_filled;  // buy quantity reaches zero after this trade
        logic limit;       // trade budget used up
        logic out_busy;
    } t_sts;

endpackage

/* rtl/obm_ctrl.sv */
module obm_ctrl
    import obm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_sts     i_sts,
    output t_cmd     o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FILL  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_BUY   = 8'b0000_1000,
        S_BCHK  = 8'b0001_0000,
        S_SELL  = 8'b0010_0000,
        S_SCHK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_STORED;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || i_sts.clr_busy;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_sts.clr_busy) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.rd_fill = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.is_add) begin
                    if (i_sts.add_ok) begin
                        o_cmd.wr_add = 1'b1;
                        n_kind = KIND_STORED;
                    end else begin
                        n_kind = KIND_DROPPED;
                    end
                    n_state = S_OUT;
                end else if (i_sts.is_match) begin
                    n_state = S_BUY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BUY: begin
                if (i_sts.buy_end) begin
                    n_kind  = KIND_DONE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_buy = 1'b1;
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                if (i_sts.buy_zero) begin
                    o_cmd.nxt_buy = 1'b1;
                    n_state = S_BUY;
                end else begin
                    n_state = S_SELL;
                end
            end
            S_SELL: begin
                if (i_sts.sell_end) begin
                    o_cmd.nxt_buy = 1'b1;
                    n_state = S_BUY;
                end else begin
                    o_cmd.rd_sell = 1'b1;
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_sts.sell_skip) begin
                    o_cmd.nxt_sell = 1'b1;
                    n_state = S_SELL;
                end else if (i_sts.limit) begin
                    n_kind  = KIND_DONE;
                    n_state = S_OUT;
                end else if (!i_sts.out_busy) begin
                    o_cmd.trade = 1'b1;
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = KIND_TRADE;
                    if (i_sts.buy_filled) begin
                        o_cmd.nxt_buy = 1'b1;
                        n_state = S_BUY;
                    end else begin
                        o_cmd.nxt_sell = 1'b1;
                        n_state = S_SELL;
                    end
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/obm_dp.sv */
module obm_dp
    import obm_pkg::*;
#(
    parameter int TICKERS    = TICKERS_DEF,
    parameter int ORDERS     = ORDERS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int QTY_BITS   = QTY_BITS_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int TI_W  = (TICKERS > 1) ? $clog2(TICKERS) : 1;
    localparam int SL_W  = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int CNT_W = $clog2(ORDERS + 1);
    localparam int DEPTH = TICKERS * ORDERS;
    localparam int AD_W  = TI_W + SL_W;
    localparam int RC_W  = $clog2(MAX_RESULTS);

    logic [PRICE_BITS-1:0] r_bp_mem [DEPTH];
    logic [QTY_BITS-1:0]   r_bq_mem [DEPTH];
    logic [PRICE_BITS-1:0] r_sp_mem [DEPTH];
    logic [QTY_BITS-1:0]   r_sq_mem [DEPTH];
    logic [CNT_W-1:0]      r_bf_mem [TICKERS];
    logic [CNT_W-1:0]      r_sf_mem [TICKERS];

    // Fill counts are cleared by a pass after reset.
    logic              r_clr_busy;
    logic [TI_W-1:0]   r_clr_idx;

    t_in_item          r_item;
    logic [CNT_W-1:0]  r_bfill, r_sfill;
    logic [CNT_W-1:0]  r_bi, r_si;
    logic [PRICE_BITS-1:0] r_bp, r_sp;
    logic [QTY_BITS-1:0]   r_bq, r_sq;
    logic [RC_W-1:0]   r_cnt;
    logic              r_ovalid;
    t_out_item         r_out;

    logic              tick_ok;
    logic [TI_W-1:0]   tix;
    logic [AD_W-1:0]   a_add, a_buy, a_sell;
    logic [QTY_BITS-1:0] m;
    logic [CNT_W-1:0]  fill_sel;
    logic [QTY_BITS-1:0] in_q;
    logic [PRICE_BITS-1:0] in_p;
    logic              is_trade;

    assign tick_ok = ({3'b0, r_item.ticker} < 13'(TICKERS));
    assign tix     = TI_W'(r_item.ticker);
    assign fill_sel = (r_item.action == ACT_ADD_BUY) ? r_bfill : r_sfill;
    assign a_add   = AD_W'(tix) * AD_W'(ORDERS) + AD_W'(fill_sel);
    assign a_buy   = AD_W'(tix) * AD_W'(ORDERS) + AD_W'(r_bi);
    assign a_sell  = AD_W'(tix) * AD_W'(ORDERS) + AD_W'(r_si);
    assign m       = (r_bq < r_sq) ? r_bq : r_sq;
    assign in_p    = PRICE_BITS'(r_item.price);
    assign in_q    = QTY_BITS'(r_item.quantity);
    assign is_trade = (i_cmd.kind == KIND_TRADE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) r_item <= i_in;
        if (i_cmd.rd_fill) begin
            r_bfill <= r_bf_mem[tix];
            r_sfill <= r_sf_mem[tix];
        end
        if (r_clr_busy) begin
            r_bf_mem[r_clr_idx] <= '0;
            r_sf_mem[r_clr_idx] <= '0;
        end else if (i_cmd.wr_add) begin
            if (r_item.action == ACT_ADD_BUY) begin
                r_bp_mem[a_add] <= in_p;
                r_bq_mem[a_add] <= in_q;
                r_bf_mem[tix]   <= r_bfill + 1'b1;
            end else begin
                r_sp_mem[a_add] <= in_p;
                r_sq_mem[a_add] <= in_q;
                r_sf_mem[tix]   <= r_sfill + 1'b1;
            end
        end
        if (i_cmd.rd_buy) begin
            r_bp <= r_bp_mem[a_buy];
            r_bq <= r_bq_mem[a_buy];
        end
        if (i_cmd.rd_sell) begin
            r_sp <= r_sp_mem[a_sell];
            r_sq <= r_sq_mem[a_sell];
        end
        if (i_cmd.trade) begin
            r_bq <= r_bq - m;
            r_bq_mem[a_buy]  <= r_bq - m;
            r_sq_mem[a_sell] <= r_sq - m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_bi       <= '0;
            r_si       <= '0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == TI_W'(TICKERS - 1)) r_clr_busy <= 1'b0;
            end
            if (i_cmd.load_item) begin
                r_bi  <= '0;
                r_si  <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.nxt_buy) begin
                r_bi <= r_bi + 1'b1;
                r_si <= '0;
            end else if (i_cmd.nxt_sell) begin
                r_si <= r_si + 1'b1;
            end
            if (i_cmd.trade) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.kind       <= i_cmd.kind;
            r_out.ticker_out <= r_item.ticker;
            r_out.buy_price  <= is_trade ? FIELD_W'(r_bp) : '0;
            r_out.sell_price <= is_trade ? FIELD_W'(r_sp) : '0;
            r_out.traded_qty <= is_trade ? FIELD_W'(m) : '0;
            r_out.last       <= !is_trade;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_comb begin
        o_sts = '0;
        o_sts.clr_busy   = r_clr_busy;
        o_sts.is_add     = (r_item.action == ACT_ADD_BUY) || (r_item.action == ACT_ADD_SELL);
        o_sts.is_match   = (r_item.action == ACT_MATCH);
        o_sts.add_ok     = tick_ok && (fill_sel < CNT_W'(ORDERS));
        o_sts.buy_end    = !tick_ok || (r_bi >= r_bfill);
        o_sts.sell_end   = (r_si >= r_sfill);
        o_sts.buy_zero   = (r_bq == '0);
        o_sts.sell_skip  = (r_sq == '0) || (r_bp < r_sp);
        o_sts.buy_filled = (r_bq <= r_sq);
        o_sts.limit      = (r_cnt == RC_W'(MAX_RESULTS - 1));
        o_sts.out_busy   = r_ovalid && i_out_stall;
    end

endmodule

/* rtl/order_book_matcher_top.sv */
// An add result is loaded into the output register after its transfer passes the fill
// read and decode states; a match gives its done result after the scan of the ticker's
// buys and sells, later still for any output stalls. Throughput: one item at a time; the
// next transfer is taken in the cycle after the last result goes into the output
// register. Reset is synchronous and active low; after it a clearing pass over all
// tickers zeroes the fill counts, and the input is stalled until the pass ends.
module order_book_matcher_top
    import obm_pkg::*;
#(
    parameter int TICKERS    = TICKERS_DEF,
    parameter int ORDERS     = ORDERS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int QTY_BITS   = QTY_BITS_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    obm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    obm_dp #(
        .TICKERS    (TICKERS),
        .ORDERS     (ORDERS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule
